@@ hdl/lfu_active_set_evictor_defines.svh @@
// Assertion macros for the LFU active set evictor.
// Both sample on clk and are off while rst_n is low.
`ifndef LFU_ACTIVE_SET_EVICTOR_DEFINES_SVH
`define LFU_ACTIVE_SET_EVICTOR_DEFINES_SVH

// Same-cycle implication.
`define LFU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu assertion failed");

// Next-cycle implication.
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu assertion failed");

`endif

@@ hdl/lfu_pkg.sv @@
package lfu_pkg;

    localparam int ACTIVE_DEPTH  = 16;
    localparam int NUM_RESOURCES = 256;
    localparam int COUNT_BITS    = 16;

    localparam int ID_W   = $clog2(NUM_RESOURCES);
    localparam int LANE_W = $clog2(ACTIVE_DEPTH);
    localparam int SIZE_W = $clog2(ACTIVE_DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX        = {COUNT_BITS{1'b1}};
    localparam logic [SIZE_W-1:0]     MAX_ACTIVE_RESET = SIZE_W'(8);

    localparam logic FUNC_REQUIRE = 1'b0;
    localparam logic FUNC_FLUSH   = 1'b1;

    localparam logic KIND_REQUIRE = 1'b0;
    localparam logic KIND_EVICT   = 1'b1;

    typedef enum logic {
        OP_REQUIRE,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] id;
    } cmd_t;

    typedef struct packed {
        logic                  valid;
        logic                  kind;
        logic [ID_W-1:0]       subject_id;
        logic                  newly_loaded;
        logic                  list_full;
        logic [COUNT_BITS-1:0] use_count;
        logic                  last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REQ,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        LANE_HOLD,
        LANE_MOVE,
        LANE_INSERT,
        LANE_SHIFT
    } lane_op_t;

endpackage

@@ hdl/lfu_front.sv @@
`include "lfu_active_set_evictor_defines.svh"

module lfu_front
    import lfu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            func,
    input  logic [ID_W-1:0] resource_id,
    output logic            busy,
    output cmd_t            q_head,
    output logic            q_valid,
    input  logic            q_pop
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              in_cmd;
    logic              push;

    // decode
    always_comb
    begin
        in_cmd.op = (func == FUNC_FLUSH) ? OP_FLUSH : OP_REQUIRE;
        in_cmd.id = resource_id;
    end

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    `LFU_ASSERT_IMPL(a_pop_nonempty, q_pop, count_reg != '0)

endmodule

@@ hdl/lfu_back.sv @@
`include "lfu_active_set_evictor_defines.svh"

module lfu_back
    import lfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] max_active,
    input  cmd_t              q_head,
    input  logic              q_valid,
    output logic              q_pop,
    output result_t           res
);

    state_t                state_reg, state_next;
    logic [ID_W-1:0]       cur_id_reg;
    logic [SIZE_W-1:0]     size_reg, size_next;
    result_t               res_reg, res_next;

    // active list lanes, count kept beside each id
    logic [ID_W-1:0]       lane_id_reg   [ACTIVE_DEPTH];
    logic [ID_W-1:0]       lane_id_next  [ACTIVE_DEPTH];
    logic [COUNT_BITS-1:0] lane_cnt_reg  [ACTIVE_DEPTH];
    logic [COUNT_BITS-1:0] lane_cnt_next [ACTIVE_DEPTH];

    // usage count memory, entries not yet written read as zero
    logic [COUNT_BITS-1:0]    cnt_mem [NUM_RESOURCES];
    logic [NUM_RESOURCES-1:0] cnt_vld_reg;
    logic [COUNT_BITS-1:0]    rd_data_reg;
    logic                     rd_vld_reg;

    logic [ACTIVE_DEPTH-1:0] hit;
    logic [LANE_W-1:0]       hit_idx;
    logic                    loaded;
    logic                    full;
    logic                    reject;
    logic [COUNT_BITS-1:0]   c_old, c_new;
    logic                    evict;
    logic [SIZE_W-1:0]       size_less;
    logic                    last_evict;
    logic                    mem_we;
    lane_op_t                lane_op;

    always_comb
    begin
        for (int i = 0; i < ACTIVE_DEPTH; i++)
        begin
            hit[i] = (SIZE_W'(i) < size_reg) && (lane_id_reg[i] == cur_id_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ACTIVE_DEPTH; i++)
        begin
            if (hit[i])
            begin
                hit_idx = LANE_W'(i);
            end
        end
    end

    assign loaded     = |hit;
    assign full       = (size_reg == SIZE_W'(ACTIVE_DEPTH));
    assign reject     = !loaded && full;
    assign c_old      = rd_vld_reg ? rd_data_reg : '0;
    assign c_new      = (c_old == COUNT_MAX) ? c_old : c_old + 1'b1;
    assign evict      = (size_reg > max_active);
    assign size_less  = size_reg - 1'b1;
    assign last_evict = (size_less <= max_active);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_head.op == OP_FLUSH) ? ST_FLUSH : ST_REQ;
                end
            end
            ST_REQ:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (!evict || last_evict)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        lane_op   = LANE_HOLD;
        size_next = size_reg;
        res_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_REQ:
            begin
                res_next.valid      = 1'b1;
                res_next.kind       = KIND_REQUIRE;
                res_next.subject_id = cur_id_reg;
                res_next.last       = 1'b1;
                if (reject)
                begin
                    res_next.list_full = 1'b1;
                    res_next.use_count = c_old;
                end
                else
                begin
                    mem_we                = 1'b1;
                    res_next.use_count    = c_new;
                    res_next.newly_loaded = !loaded;
                    if (loaded)
                    begin
                        lane_op = LANE_MOVE;
                    end
                    else
                    begin
                        lane_op   = LANE_INSERT;
                        size_next = size_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (evict)
                begin
                    lane_op             = LANE_SHIFT;
                    size_next           = size_less;
                    res_next.valid      = 1'b1;
                    res_next.kind       = KIND_EVICT;
                    res_next.subject_id = lane_id_reg[0];
                    res_next.use_count  = lane_cnt_reg[0];
                    res_next.last       = last_evict;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // per-lane update: move after a count rise, insert of a new id, or shift out
    for (genvar g = 0; g < ACTIVE_DEPTH; g++)
    begin : g_lane
        logic [ID_W-1:0]       up_id, dn_id;
        logic [COUNT_BITS-1:0] up_cnt, dn_cnt;
        logic                  up_in, dn_in;
        logic                  self_in, at_end;

        if (g < ACTIVE_DEPTH - 1)
        begin : g_up
            assign up_id  = lane_id_reg[g+1];
            assign up_cnt = lane_cnt_reg[g+1];
            assign up_in  = (SIZE_W'(g + 1) < size_reg);
        end
        else
        begin : g_top
            assign up_id  = lane_id_reg[g];
            assign up_cnt = lane_cnt_reg[g];
            assign up_in  = 1'b0;
        end

        if (g > 0)
        begin : g_dn
            assign dn_id  = lane_id_reg[g-1];
            assign dn_cnt = lane_cnt_reg[g-1];
            assign dn_in  = 1'b1;
        end
        else
        begin : g_bottom
            assign dn_id  = lane_id_reg[g];
            assign dn_cnt = lane_cnt_reg[g];
            assign dn_in  = 1'b0;
        end

        assign self_in = (SIZE_W'(g) < size_reg);
        assign at_end  = (SIZE_W'(g) == size_reg);

        always_comb
        begin
            lane_id_next[g]  = lane_id_reg[g];
            lane_cnt_next[g] = lane_cnt_reg[g];
            unique case (lane_op)
                LANE_HOLD:
                begin
                    lane_id_next[g] = lane_id_reg[g];
                end
                LANE_SHIFT:
                begin
                    lane_id_next[g]  = up_id;
                    lane_cnt_next[g] = up_cnt;
                end
                LANE_MOVE:
                begin
                    if (self_in && (LANE_W'(g) >= hit_idx))
                    begin
                        if (up_in && (up_cnt < c_new))
                        begin
                            lane_id_next[g]  = up_id;
                            lane_cnt_next[g] = up_cnt;
                        end
                        else if ((LANE_W'(g) == hit_idx) || (lane_cnt_reg[g] < c_new))
                        begin
                            lane_id_next[g]  = cur_id_reg;
                            lane_cnt_next[g] = c_new;
                        end
                    end
                end
                LANE_INSERT:
                begin
                    if (self_in || at_end)
                    begin
                        if (dn_in && (dn_cnt > c_new))
                        begin
                            lane_id_next[g]  = dn_id;
                            lane_cnt_next[g] = dn_cnt;
                        end
                        else if (at_end || (lane_cnt_reg[g] > c_new))
                        begin
                            lane_id_next[g]  = cur_id_reg;
                            lane_cnt_next[g] = c_new;
                        end
                    end
                end
                default:
                begin
                    lane_id_next[g] = lane_id_reg[g];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            size_reg    <= '0;
            cnt_vld_reg <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            res_reg   <= res_next;
            if (mem_we)
            begin
                cnt_vld_reg[cur_id_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_id_reg  <= lane_id_next;
        lane_cnt_reg <= lane_cnt_next;
        if (q_pop)
        begin
            cur_id_reg  <= q_head.id;
            rd_data_reg <= cnt_mem[q_head.id];
            rd_vld_reg  <= cnt_vld_reg[q_head.id];
        end
        if (mem_we)
        begin
            cnt_mem[cur_id_reg] <= c_new;
        end
    end

    assign res = res_reg;

    `LFU_ASSERT_IMPL(a_size_bound, 1'b1, size_reg <= SIZE_W'(ACTIVE_DEPTH))
    `LFU_ASSERT_NEXT(a_evict_shrinks, (state_reg == ST_FLUSH) && evict, size_reg == $past(size_reg) - 1'b1)
    `LFU_ASSERT_NEXT(a_reject_keeps, (state_reg == ST_REQ) && reject, size_reg == $past(size_reg))
    `LFU_ASSERT_IMPL(a_require_last, res_reg.valid && (res_reg.kind == KIND_REQUIRE), res_reg.last)

endmodule

@@ hdl/lfu_active_set_evictor.sv @@
// Channel     Direction  Signals                                        Transaction
// ---------   ---------  ---------------------------------------------  -------------------------
// command     in         start, busy, func, resource_id                 start && !busy
// result      out        result_valid, kind, subject_id, newly_loaded,  result_valid (one cycle)
//                        list_full, use_count, last
// config      in         cfg_valid, cfg_ready, max_active               cfg_valid && cfg_ready
//
// Sequence: a require holds the executor for a registered count read, then count write and
//   list reorder; a flush for the pop, then each eviction in turn, or the flush state alone
//   if none. Results leave through a register the cycle after the executor makes them.
// Reset: rst_n async low; counts read as zero through per-entry valid bits, no sweep;
//   max_active comes up as 8, the active list empty.
// Stalls: busy is high only when the 2-deep command queue is full; the receiver cannot stall.

`include "lfu_active_set_evictor_defines.svh"

module lfu_active_set_evictor
    import lfu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // command
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [ID_W-1:0]       resource_id,

    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     max_active,

    // results
    output logic                  result_valid,
    output logic                  kind,
    output logic [ID_W-1:0]       subject_id,
    output logic                  newly_loaded,
    output logic                  list_full,
    output logic [COUNT_BITS-1:0] use_count,
    output logic                  last
);

    logic [SIZE_W-1:0] max_active_reg;
    cmd_t              q_head;
    logic              q_valid;
    logic              q_pop;
    result_t           res;

    // config write always accepted; only changed while idle is a rule for the user, unchecked by the block
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_active_reg <= MAX_ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_active_reg <= max_active;
        end
    end

    // front: decode commands into the queue
    lfu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .resource_id (resource_id),
        .busy        (busy),
        .q_head      (q_head),
        .q_valid     (q_valid),
        .q_pop       (q_pop)
    );

    // back: count memory, sorted active list, eviction sequencing
    lfu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_active (max_active_reg),
        .q_head     (q_head),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .res        (res)
    );

    assign result_valid = res.valid;
    assign kind         = res.kind;
    assign subject_id   = res.subject_id;
    assign newly_loaded = res.newly_loaded;
    assign list_full    = res.list_full;
    assign use_count    = res.use_count;
    assign last         = res.last;

    `LFU_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, max_active_reg == $past(max_active))

endmodule

@@ verif/lfu_active_set_evictor_test.sv @@
`timescale 1ns / 1ps

import lfu_pkg::*;

// Scoreboard: tracks usage counts and the active list, queues the expected results
// of every accepted command and compares each observed result against the oldest one.
class lfu_scoreboard;

    logic [COUNT_BITS-1:0] use_counts [NUM_RESOURCES];
    bit                    is_loaded  [NUM_RESOURCES];
    logic [ID_W-1:0]       active_list [ACTIVE_DEPTH];
    int unsigned           list_len;
    int unsigned           keep_limit;
    result_t               expected_q [$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           evictions;
    int unsigned           full_hits;

    function new();
        foreach (use_counts[i])
        begin
            use_counts[i] = '0;
            is_loaded[i]  = 1'b0;
        end
        foreach (active_list[i])
            active_list[i] = '0;
        list_len   = 0;
        keep_limit = MAX_ACTIVE_RESET;
        mismatches = 0;
        checked    = 0;
        evictions  = 0;
        full_hits  = 0;
    endfunction

    function void set_keep_limit(logic [SIZE_W-1:0] value);
        keep_limit = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // stable insertion sort, ascending count; ties keep their current list order
    function void reorder_by_count();
        int unsigned     i;
        int unsigned     j;
        logic [ID_W-1:0] moving;
        for (i = 1; i < list_len; i++)
        begin
            moving = active_list[i];
            j = i;
            while (j > 0 && use_counts[active_list[j-1]] > use_counts[moving])
            begin
                active_list[j] = active_list[j-1];
                j--;
            end
            active_list[j] = moving;
        end
    endfunction

    function void note_command(logic cmd_func, logic [ID_W-1:0] cmd_id);
        result_t         res;
        logic [ID_W-1:0] victim;
        res = '0;
        res.valid = 1'b1;
        if (cmd_func == FUNC_REQUIRE)
        begin
            res.kind       = KIND_REQUIRE;
            res.subject_id = cmd_id;
            res.last       = 1'b1;
            if (!is_loaded[cmd_id] && list_len >= ACTIVE_DEPTH)
            begin
                // refused: count stays as it is
                res.list_full = 1'b1;
                res.use_count = use_counts[cmd_id];
                full_hits++;
            end
            else
            begin
                if (!is_loaded[cmd_id])
                begin
                    active_list[list_len] = cmd_id;
                    list_len++;
                    is_loaded[cmd_id] = 1'b1;
                    res.newly_loaded  = 1'b1;
                end
                if (use_counts[cmd_id] != COUNT_MAX)
                    use_counts[cmd_id]++;
                reorder_by_count();
                res.use_count = use_counts[cmd_id];
            end
            expected_q = {expected_q, res};
        end
        else
        begin
            while (list_len > keep_limit && list_len > 0)
            begin
                victim = active_list[0];
                for (int k = 1; k < list_len; k++)
                    active_list[k-1] = active_list[k];
                list_len--;
                is_loaded[victim] = 1'b0;
                res.kind       = KIND_EVICT;
                res.subject_id = victim;
                res.use_count  = use_counts[victim];
                res.last       = (list_len > keep_limit) ? 1'b0 : 1'b1;
                expected_q = {expected_q, res};
                evictions++;
            end
        end
    endfunction

    function bit field_ok(string field, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, want, seen);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function void check_result(result_t seen);
        result_t want;
        bit      ok;
        checked++;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual id %0h kind %0b",
                     $time, seen.subject_id, seen.kind);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        ok = 1'b1;
        ok &= field_ok("kind",         32'(want.kind),         32'(seen.kind));
        ok &= field_ok("subject_id",   32'(want.subject_id),   32'(seen.subject_id));
        ok &= field_ok("newly_loaded", 32'(want.newly_loaded), 32'(seen.newly_loaded));
        ok &= field_ok("list_full",    32'(want.list_full),    32'(seen.list_full));
        ok &= field_ok("use_count",    32'(want.use_count),    32'(seen.use_count));
        ok &= field_ok("last",         32'(want.last),         32'(seen.last));
        if (!ok)
            mismatches++;
    endfunction

endclass

module lfu_active_set_evictor_test;

    // settle time after the last expected result: queue of 2 plus executor cycles
    localparam int SETTLE_CYCLES = 24;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 47;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [ID_W-1:0]       resource_id;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     max_active;
    logic                  result_valid;
    logic                  kind;
    logic [ID_W-1:0]       subject_id;
    logic                  newly_loaded;
    logic                  list_full;
    logic [COUNT_BITS-1:0] use_count;
    logic                  last;

    lfu_scoreboard sb;
    result_t       observed;
    int unsigned   commands_sent;
    int unsigned   settings_used;
    int            idle_cycles;

    lfu_active_set_evictor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .resource_id  (resource_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .max_active   (max_active),
        .result_valid (result_valid),
        .kind         (kind),
        .subject_id   (subject_id),
        .newly_loaded (newly_loaded),
        .list_full    (list_full),
        .use_count    (use_count),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Command transaction. Called at the edge where the previous command was taken
    // (or from idle), so start changes at most once per time step. A gap lowers
    // start first; otherwise the next command follows back to back.
    task automatic send_command(input logic cmd_func, input logic [ID_W-1:0] cmd_id,
                                input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        func        <= cmd_func;
        resource_id <= cmd_id;
        // busy read right after the edge is its value during the cycle just ended
        do
            @(posedge clk);
        while (busy);
        sb.note_command(cmd_func, cmd_id);
        commands_sent++;
    endtask

    // Drop start and wait until every expected result is in, then give trailing
    // flushes with no result time to leave the queue and executor.
    task automatic settle_block();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only issued while the block is idle.
    task automatic write_max_active(input logic [SIZE_W-1:0] value);
        cfg_valid  <= 1'b1;
        max_active <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_keep_limit(value);
        settings_used++;
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 14);
        return 0;
    endfunction

    // Random mix: mostly requires from a pool a bit larger than the list, so the
    // list fills, reorders and hits full; some ids from the whole range; some flushes
    // with random (ignored) id bits.
    task automatic run_random_phase(input int items, input bit allow_gaps);
        logic [ID_W-1:0] pool_base;
        logic [ID_W-1:0] id;
        logic            f;
        pool_base = ID_W'($urandom_range(0, NUM_RESOURCES - 1));
        for (int n = 0; n < items; n++)
        begin
            f  = ($urandom_range(0, 99) < 15) ? FUNC_FLUSH : FUNC_REQUIRE;
            if ($urandom_range(0, 9) < 8)
                id = pool_base + ID_W'($urandom_range(0, 19));
            else
                id = ID_W'($urandom_range(0, NUM_RESOURCES - 1));
            send_command(f, id, pick_gap(allow_gaps));
        end
    endtask

    // Results are sampled at the edge that ends their cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            observed.valid        = 1'b1;
            observed.kind         = kind;
            observed.subject_id   = subject_id;
            observed.newly_loaded = newly_loaded;
            observed.list_full    = list_full;
            observed.use_count    = use_count;
            observed.last         = last;
            sb.check_result(observed);
        end
    end

    // Watchdog: any command, result or register transaction restarts the count.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [SIZE_W-1:0] settings [7];
        sb = new();
        commands_sent = 0;
        settings_used = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        func        <= FUNC_REQUIRE;
        resource_id <= '0;
        cfg_valid   <= 1'b0;
        max_active  <= MAX_ACTIVE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, max_active at its reset value of 8.
        send_command(FUNC_REQUIRE, 8'h00, pick_gap(1));  // lowest id, new
        send_command(FUNC_REQUIRE, 8'hFF, pick_gap(1));  // highest id, new
        send_command(FUNC_REQUIRE, 8'h00, pick_gap(1));  // already loaded, moves back
        send_command(FUNC_FLUSH,   8'h00, pick_gap(1));  // nothing to evict
        for (int k = 1; k <= 14; k++)
            send_command(FUNC_REQUIRE, ID_W'(k), pick_gap(1));  // fills the list
        send_command(FUNC_REQUIRE, 8'hC8, pick_gap(1));  // new id on full list
        send_command(FUNC_REQUIRE, 8'hFF, pick_gap(1));  // loaded id on full list
        send_command(FUNC_FLUSH,   8'hFF, pick_gap(1));  // evicts down to 8
        settle_block();

        // keep nothing: flush empties the list
        write_max_active(SIZE_W'(0));
        send_command(FUNC_FLUSH, 8'h5A, 0);
        settle_block();

        // Random phases over several settings: full depth, above depth, zero, one,
        // near depth, and two mid values; the last phase runs with no idling.
        settings[0] = SIZE_W'(16);
        settings[1] = SIZE_W'(31);
        settings[2] = SIZE_W'(0);
        settings[3] = SIZE_W'(1);
        settings[4] = SIZE_W'(15);
        settings[5] = SIZE_W'(5);
        settings[6] = SIZE_W'($urandom_range(2, 14));
        for (int p = 0; p < 7; p++)
        begin
            write_max_active(settings[p]);
            run_random_phase(PHASE_ITEMS, p != 6);
            settle_block();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        $display("covered %0d commands over %0d max_active settings: %0d results checked,",
                 commands_sent, settings_used, sb.checked);
        $display("including %0d evictions and %0d full-list refusals",
                 sb.evictions, sb.full_hits);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_front.sv
hdl/lfu_back.sv
hdl/lfu_active_set_evictor.sv
verif/lfu_active_set_evictor_test.sv
